// ----- sv/kcs_pkg.sv -----
// kcs_pkg: shared constants, opcodes, register indexes and divider types
// for the keyframe clip sampler; no dependencies
package kcs_pkg;

   localparam int MAX_KEYS = 64;
   localparam int KEY_AW   = $clog2(MAX_KEYS);
   localparam int KCNT_W   = 7;
   localparam int DIV_NW   = 41;
   localparam int DIV_DW   = 32;
   localparam int DIV_CW   = $clog2(DIV_NW + 1);
   localparam int ENTRY_W  = 48;

   localparam logic OP_KEY_WRITE = 1'b0;
   localparam logic OP_TICK      = 1'b1;

   localparam logic [2:0] REG_START_FRAME = 3'd0;
   localparam logic [2:0] REG_END_FRAME   = 3'd1;
   localparam logic [2:0] REG_FRAME_RATE  = 3'd2;
   localparam logic [2:0] REG_PLAY_SPEED  = 3'd3;
   localparam logic [2:0] REG_LOOP_ENABLE = 3'd4;
   localparam logic [2:0] REG_KEY_COUNT   = 3'd5;

   localparam logic [15:0] RATE_RESET  = 16'd6144;
   localparam logic [15:0] SPEED_RESET = 16'd256;
   localparam logic [16:0] BLEND_ONE   = 17'h10000;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] dividend;
      logic [DIV_DW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_NW-1:0] quotient;
      logic [DIV_DW-1:0] remainder;
   } div_rsp_type;

endpackage

// ----- sv/kcs_key_ram.sv -----
// kcs_key_ram: key table, one write port and one registered read port
// depends on kcs_pkg
module kcs_key_ram
   import kcs_pkg::*;
(
   input  logic               clock,
   input  logic               we,
   input  logic [KEY_AW-1:0]  waddr,
   input  logic [ENTRY_W-1:0] wdata,
   input  logic               re,
   input  logic [KEY_AW-1:0]  raddr,
   output logic [ENTRY_W-1:0] rdata
);

   logic [ENTRY_W-1:0] mem [MAX_KEYS];
   logic [ENTRY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/kcs_divider.sv -----
// kcs_divider: restoring unsigned divider, one quotient bit per cycle
// depends on kcs_pkg
module kcs_divider
   import kcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic              busy_ff, done_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic [DIV_NW-1:0] quo_ff;
   logic [DIV_DW-1:0] rem_ff, dsr_ff;
   logic [DIV_DW:0]   shifted, diff;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[DIV_NW-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = shifted >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CW'(DIV_NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (req.start) begin
         quo_ff <= req.dividend;
         dsr_ff <= req.divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_NW-2:0], fits};
         rem_ff <= fits ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ----- sv/keyframe_clip_sampler_top.sv -----
// keyframe_clip_sampler_top: register file, clip timing, key search and output
// depends on kcs_pkg, kcs_key_ram, kcs_divider
//
//  channel | dir | handshake            | contents
//  req     | in  | req_tvalid/tready    | tuser opcode, tdata key and tick fields
//  rsp     | out | rsp_tvalid/tready    | tdata frame, offsets, blend, flags
//  csr     | in  | apb psel/penable     | six clip registers
//
// one request at a time: a tick is taken, then runs the timing steps (two multiplies
// and an add, then a clamp, or a modulo in the serial divider when looping), then the
// key scan over the table memory, a blend division (skipped when both keys share a
// frame) and the response load. the shared serial divider and the single memory
// read port set the pace. a key write, or a tick on a clip of zero span, skips the
// timing part.
// reset clears the clip registers, elapsed time and handshake state; the key table is
// not cleared. a new request is taken while the last response still waits.
module keyframe_clip_sampler_top
   import kcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [0] opcode
   input  logic         req_tuser,
   // [5:0] key_index, [21:6] key_frame, [53:22] key_offset,
   // [77:54] delta_time, [93:78] target_frame, [95:94] zero
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] whole_frame, [47:16] previous_offset, [79:48] next_offset,
   // [96:80] blend, [97] clip_ended, [98] frame_reached, [103:99] zero
   output logic [103:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL1, S_MUL2, S_ADD, S_CLAMP, S_MODGO, S_MODW,
      S_SINIT, S_SRCH, S_BLGO, S_BLW, S_DONE
   } state_type;

   state_type state_ff;

   logic [15:0]       start_ff, end_ff, rate_ff, speed_ff;
   logic              loop_ff;
   logic [KCNT_W-1:0] kcount_ff;
   logic [31:0]       elapsed_ff;
   logic [23:0]       dt_ff;
   logic [15:0]       target_ff;
   logic [39:0]       prod_ff, mag_ff;
   logic [41:0]       t_ff;
   logic [KCNT_W-1:0] idx_ff, chk_idx_ff;
   logic              chk_vld_ff, bneg_ff;
   logic [15:0]       pf_ff, nf_ff;
   logic [31:0]       po_ff, no_ff;
   logic [16:0]       blend_ff;
   logic              rsp_valid_ff;
   logic [103:0]      rsp_data_ff;

   logic              req_acc, csr_wr;
   logic [31:0]       span, t_rep, pos;
   logic [KCNT_W-1:0] n_keys;
   logic [15:0]       speed_mag;
   logic [40:0]       t_abs;
   logic [55:0]       prod2;
   logic [41:0]       step;
   logic              rd_en, take_prev, found;
   logic [ENTRY_W-1:0] rd_data;
   logic [15:0]       kf;
   logic [32:0]       num, num_abs;
   logic [16:0]       den, den_abs;
   logic [31:0]       mod_r;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_START_FRAME: csr_prdata = {16'h0, start_ff};
         REG_END_FRAME:   csr_prdata = {16'h0, end_ff};
         REG_FRAME_RATE:  csr_prdata = {16'h0, rate_ff};
         REG_PLAY_SPEED:  csr_prdata = {16'h0, speed_ff};
         REG_LOOP_ENABLE: csr_prdata = {31'h0, loop_ff};
         REG_KEY_COUNT:   csr_prdata = {25'h0, kcount_ff};
         default:         csr_prdata = 32'h0;
      endcase
   end

   assign span      = (end_ff > start_ff) ? {end_ff - start_ff, 16'h0} : 32'h0;
   assign t_rep     = (elapsed_ff > span) ? span : elapsed_ff;
   assign pos       = (span == 32'h0) ? {start_ff, 16'h0} : {start_ff, 16'h0} + t_rep;
   assign n_keys    = (kcount_ff > KCNT_W'(MAX_KEYS)) ? KCNT_W'(MAX_KEYS) : kcount_ff;
   assign speed_mag = speed_ff[15] ? 16'(-speed_ff) : speed_ff;
   assign prod2     = prod_ff * rate_ff;
   assign step      = speed_ff[15] ? 42'(-{2'b0, mag_ff}) : {2'b0, mag_ff};
   assign t_abs     = t_ff[41] ? 41'(-t_ff) : t_ff[40:0];
   assign mod_r     = div_rsp.remainder;

   // key table: write at request accept, scan reads one slot a cycle
   assign rd_en = (state_ff == S_SRCH) && (idx_ff < n_keys);
   kcs_key_ram u_ram (
      .clock (clock),
      .we    (req_acc && (req_tuser == OP_KEY_WRITE)
              && ({1'b0, req_tdata[5:0]} < KCNT_W'(MAX_KEYS))),
      .waddr (req_tdata[KEY_AW-1:0]),
      .wdata ({req_tdata[21:6], req_tdata[53:22]}),
      .re    (rd_en),
      .raddr (idx_ff[KEY_AW-1:0]),
      .rdata (rd_data)
   );

   assign kf        = rd_data[47:32];
   assign take_prev = (chk_idx_ff == '0) || ({kf, 16'h0} <= pos);
   assign found     = ({kf, 16'h0} >= pos) || (chk_idx_ff == n_keys - 1'b1);

   assign num     = {1'b0, pos} - {1'b0, pf_ff, 16'h0};
   assign den     = {1'b0, nf_ff} - {1'b0, pf_ff};
   assign num_abs = num[32] ? 33'(-num) : num;
   assign den_abs = den[16] ? 17'(-den) : den;

   always_comb begin
      div_req = '0;
      if (state_ff == S_MODGO) begin
         div_req.start    = 1'b1;
         div_req.dividend = t_abs;
         div_req.divisor  = span;
      end else if (state_ff == S_BLGO && nf_ff != pf_ff) begin
         div_req.start    = 1'b1;
         div_req.dividend = DIV_NW'(num_abs);
         div_req.divisor  = DIV_DW'(den_abs);
      end
   end

   kcs_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= '0;
         end_ff       <= '0;
         rate_ff      <= RATE_RESET;
         speed_ff     <= SPEED_RESET;
         loop_ff      <= 1'b0;
         kcount_ff    <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (csr_wr) begin
            unique case (csr_paddr[4:2])
               REG_START_FRAME: start_ff  <= csr_pwdata[15:0];
               REG_END_FRAME:   end_ff    <= csr_pwdata[15:0];
               REG_FRAME_RATE:  rate_ff   <= csr_pwdata[15:0];
               REG_PLAY_SPEED:  speed_ff  <= csr_pwdata[15:0];
               REG_LOOP_ENABLE: loop_ff   <= csr_pwdata[0];
               REG_KEY_COUNT:   kcount_ff <= csr_pwdata[6:0];
               default: ;
            endcase
         end
         // the done state reloads the response itself
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  dt_ff     <= req_tdata[77:54];
                  target_ff <= req_tdata[93:78];
                  state_ff  <= (req_tuser == OP_TICK && span != 32'h0) ? S_MUL1 : S_SINIT;
               end
            end
            S_MUL1: begin
               prod_ff  <= dt_ff * speed_mag;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               mag_ff   <= prod2[55:16];
               state_ff <= S_ADD;
            end
            S_ADD: begin
               t_ff     <= {10'h0, elapsed_ff} + step;
               state_ff <= loop_ff ? S_MODGO : S_CLAMP;
            end
            S_CLAMP: begin
               if (t_ff[41]) begin
                  elapsed_ff <= '0;
               end else if (t_ff > {10'h0, span}) begin
                  elapsed_ff <= span;
               end else begin
                  elapsed_ff <= t_ff[31:0];
               end
               state_ff <= S_SINIT;
            end
            S_MODGO: state_ff <= S_MODW;
            S_MODW: begin
               if (div_rsp.done) begin
                  // truncating modulo, then pulled up into range for negative time
                  elapsed_ff <= (t_ff[41] && mod_r != 32'h0) ? span - mod_r : mod_r;
                  state_ff   <= S_SINIT;
               end
            end
            S_SINIT: begin
               idx_ff     <= '0;
               chk_vld_ff <= 1'b0;
               if (n_keys == '0) begin
                  po_ff    <= '0;
                  no_ff    <= '0;
                  blend_ff <= '0;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_SRCH;
               end
            end
            S_SRCH: begin
               chk_vld_ff <= rd_en;
               chk_idx_ff <= idx_ff;
               if (rd_en) begin
                  idx_ff <= idx_ff + 1'b1;
               end
               if (chk_vld_ff) begin
                  if (take_prev) begin
                     pf_ff <= kf;
                     po_ff <= rd_data[31:0];
                  end
                  if (found) begin
                     nf_ff    <= kf;
                     no_ff    <= rd_data[31:0];
                     state_ff <= S_BLGO;
                  end
               end
            end
            S_BLGO: begin
               bneg_ff <= num[32] ^ den[16];
               if (nf_ff == pf_ff) begin
                  blend_ff <= '0;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_BLW;
               end
            end
            S_BLW: begin
               if (div_rsp.done) begin
                  if (bneg_ff) begin
                     blend_ff <= '0;
                  end else if (div_rsp.quotient > {24'h0, BLEND_ONE}) begin
                     blend_ff <= BLEND_ONE;
                  end else begin
                     blend_ff <= div_rsp.quotient[16:0];
                  end
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {5'h0,
                                   pos >= {target_ff, 16'h0},
                                   !loop_ff && (elapsed_ff >= span),
                                   blend_ff, no_ff, po_ff, pos[31:16]};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_blend_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[96:80] <= BLEND_ONE))
      else $error("blend above one");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_MODW || state_ff == S_BLW))
      else $error("divider result with no waiting state");

   a_wrap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MODW && div_rsp.done) |=> (elapsed_ff < span))
      else $error("wrapped time outside clip");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH) |-> (idx_ff <= n_keys))
      else $error("key scan past table");

endmodule

// ----- tb/keyframe_clip_checker.sv -----
// keyframe_clip_checker: watches the request, response and csr channels of the
// keyframe clip sampler, predicts each response and compares; depends on kcs_pkg
`timescale 1ns / 100ps
module keyframe_clip_checker
   import kcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic         req_tuser,
   input  logic [95:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           pending
);

   typedef struct packed {
      logic        frame_reached;
      logic        clip_ended;
      logic [16:0] blend;
      logic [31:0] next_offset;
      logic [31:0] previous_offset;
      logic [15:0] whole_frame;
   } clip_sample_t;

   logic [15:0]        start_frame, end_frame, frame_rate;
   logic signed [15:0] play_speed;
   logic               loop_enable;
   logic [6:0]         key_count;
   logic [31:0]        elapsed;
   logic [15:0]        key_frame_mem [MAX_KEYS];
   logic [31:0]        key_offset_mem [MAX_KEYS];
   clip_sample_t       sample_queue [$];

   assign pending = sample_queue.size();

   function automatic clip_sample_t sample_clip(logic op, logic [95:0] d);
      longint span, t, pos, kf, num, den, b, step, sf;
      longint unsigned speed_mag, mag, dt;
      int n, pi, ni;
      clip_sample_t r;
      sf = start_frame;
      span = (end_frame > start_frame) ? (longint'(end_frame) - sf) * 65536 : 0;
      if (op == OP_KEY_WRITE) begin
         key_frame_mem[d[5:0]] = d[21:6];
         key_offset_mem[d[5:0]] = d[53:22];
      end else if (span != 0) begin
         dt = d[77:54];
         speed_mag = (play_speed < 0) ? longint'(-longint'(play_speed)) : play_speed;
         mag = (dt * speed_mag * longint'(frame_rate)) >> 16;
         step = (play_speed < 0) ? -longint'(mag) : longint'(mag);
         t = longint'(elapsed) + step;
         if (loop_enable) begin
            t = t % span;
            if (t < 0) t = t + span;
         end else begin
            if (t > span) t = span;
            if (t < 0) t = 0;
         end
         elapsed = t[31:0];
      end
      // position in q16.16, elapsed held at the duration until a tick fixes it
      t = elapsed;
      if (span == 0) pos = sf * 65536;
      else pos = sf * 65536 + ((t > span) ? span : t);
      n = (key_count > MAX_KEYS) ? MAX_KEYS : key_count;
      r = '0;
      if (n > 0) begin
         pi = 0;
         ni = n - 1;
         for (int i = 0; i < n; i++) begin
            kf = longint'(key_frame_mem[i]) * 65536;
            if (kf <= pos) pi = i;
            if (kf >= pos) begin
               ni = i;
               break;
            end
         end
         r.previous_offset = key_offset_mem[pi];
         r.next_offset = key_offset_mem[ni];
         if (key_frame_mem[ni] != key_frame_mem[pi]) begin
            num = pos - longint'(key_frame_mem[pi]) * 65536;
            den = longint'(key_frame_mem[ni]) - longint'(key_frame_mem[pi]);
            b = num / den;
            if (b < 0) b = 0;
            if (b > 65536) b = 65536;
            r.blend = b[16:0];
         end
      end
      r.whole_frame = pos[31:16];
      r.clip_ended = !loop_enable && (t >= span);
      r.frame_reached = pos >= longint'(d[93:78]) * 65536;
      return r;
   endfunction

   always @(posedge clock) begin
      clip_sample_t got, want;
      if (reset) begin
         start_frame <= '0;
         end_frame <= '0;
         frame_rate <= RATE_RESET;
         play_speed <= SPEED_RESET;
         loop_enable <= 1'b0;
         key_count <= '0;
         elapsed = '0;
         sample_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_START_FRAME: start_frame <= csr_pwdata[15:0];
               REG_END_FRAME:   end_frame <= csr_pwdata[15:0];
               REG_FRAME_RATE:  frame_rate <= csr_pwdata[15:0];
               REG_PLAY_SPEED:  play_speed <= csr_pwdata[15:0];
               REG_LOOP_ENABLE: loop_enable <= csr_pwdata[0];
               REG_KEY_COUNT:   key_count <= csr_pwdata[6:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            sample_queue.insert(sample_queue.size(), sample_clip(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[98:0];
            if (sample_queue.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = sample_queue.pop_front();
               if (got.whole_frame !== want.whole_frame)
                  $error("whole_frame: expected %0d, got %0d", want.whole_frame, got.whole_frame);
               if (got.previous_offset !== want.previous_offset)
                  $error("previous_offset: expected %h, got %h",
                         want.previous_offset, got.previous_offset);
               if (got.next_offset !== want.next_offset)
                  $error("next_offset: expected %h, got %h", want.next_offset, got.next_offset);
               if (got.blend !== want.blend)
                  $error("blend: expected %0d, got %0d", want.blend, got.blend);
               if (got.clip_ended !== want.clip_ended)
                  $error("clip_ended: expected %0d, got %0d", want.clip_ended, got.clip_ended);
               if (got.frame_reached !== want.frame_reached)
                  $error("frame_reached: expected %0d, got %0d",
                         want.frame_reached, got.frame_reached);
               if (got !== want || rsp_tdata[103:99] !== 5'b0)
                  fail_count <= fail_count + 1;
            end
         end
      end
   end

endmodule

// ----- tb/testbench.sv -----
// testbench: stimulus and verdict for keyframe_clip_sampler_top
// depends on kcs_pkg, keyframe_clip_checker and the sampler rtl
`timescale 1ns / 100ps
module testbench;
   import kcs_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0, req_tready;
   logic         req_tuser = 1'b0;
   // [5:0] key_index, [21:6] key_frame, [53:22] key_offset,
   // [77:54] delta_time, [93:78] target_frame, [95:94] zero
   logic [95:0]  req_tdata = '0;
   logic         rsp_tvalid, rsp_tready = 1'b0;
   // [15:0] whole_frame, [47:16] previous_offset, [79:48] next_offset,
   // [96:80] blend, [97] clip_ended, [98] frame_reached, [103:99] zero
   logic [103:0] rsp_tdata;
   logic         csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0, csr_prdata;
   logic         csr_pready;
   int           fail_count, pending;
   int           sent, ticks, phases, stall_left, stall_draw;
   bit           gaps_on, stalls_on;
   logic [15:0]  cur_start, cur_end;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   keyframe_clip_sampler_top u_dut (.*);

   keyframe_clip_checker u_checker (.*);

   initial begin
      #2_000_000;
      $display("timeout with %0d responses outstanding", pending);
      $display("testbench failed");
      $finish;
   end

   // response side holds rsp_tready low for a random stall after each response, when stalls are on
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         stall_draw = stalls_on ? $urandom_range(0, 3) : 0;
         stall_left <= stall_draw;
         rsp_tready <= (stall_draw == 0);
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end
   end

   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_request(logic op, logic [5:0] idx, logic [15:0] kframe,
                               logic [31:0] koff, logic [23:0] dt, logic [15:0] target);
      int gap;
      gap = gaps_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser <= op;
      req_tdata <= {2'b00, target, dt, koff, kframe, idx};
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      sent++;
      if (op == OP_TICK) ticks++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic configure(logic [15:0] sf, logic [15:0] ef, logic [15:0] rate,
                            logic [15:0] speed, logic lp, logic [6:0] count);
      wait_idle();
      csr_write(REG_START_FRAME, {16'($urandom), sf});
      csr_write(REG_END_FRAME, {16'($urandom), ef});
      csr_write(REG_FRAME_RATE, {16'($urandom), rate});
      csr_write(REG_PLAY_SPEED, {16'($urandom), speed});
      csr_write(REG_LOOP_ENABLE, {31'($urandom), lp});
      csr_write(REG_KEY_COUNT, {25'($urandom), count});
      cur_start = sf;
      cur_end = ef;
      phases++;
   endtask

   // key frames laid out in order across the clip, a few beyond each end
   task automatic load_sorted_keys(int n);
      int lo, hi;
      lo = (cur_start > 20) ? cur_start - 20 : 0;
      hi = (cur_end > lo) ? cur_end + 20 : lo + 40;
      if (hi > 65535) hi = 65535;
      for (int i = 0; i < n && i < MAX_KEYS; i++)
         send_request(OP_KEY_WRITE, 6'(i), 16'(lo + (hi - lo) * i / n + $urandom_range(0, 1)),
                      $urandom, 24'($urandom), 16'($urandom));
   endtask

   function automatic logic [23:0] pick_delta();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return 24'($urandom_range(0, 4096));
      if (r < 9) return 24'($urandom_range(0, 65536));
      return 24'($urandom);
   endfunction

   function automatic logic [15:0] pick_speed();
      int r;
      r = $urandom_range(0, 5);
      if (r == 0) return 16'($urandom);
      if (r < 4) return 16'($urandom_range(0, 1024));
      return 16'(-$urandom_range(1, 1024));
   endfunction

   task automatic random_phase(int count);
      logic [15:0] kf, target;
      for (int i = 0; i < count; i++) begin
         target = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                  : 16'(cur_start + $urandom_range(0, 300));
         if ($urandom_range(0, 99) < 12) begin
            kf = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                 : 16'(cur_start + $urandom_range(0, 300));
            send_request(OP_KEY_WRITE, 6'($urandom), kf, $urandom, 24'($urandom), target);
         end else begin
            send_request(OP_TICK, 6'($urandom), 16'($urandom), $urandom, pick_delta(),
                         target);
         end
      end
   endtask

   initial begin
      logic [15:0] sf;
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every slot while the table is still empty so no unwritten key is read
      for (int i = 0; i < MAX_KEYS; i++)
         send_request(OP_KEY_WRITE, 6'(i), 16'(i * 4 + 90), $urandom, 24'($urandom),
                      16'($urandom));

      // directed: clamped clip, then extremes of the fields
      configure(16'd100, 16'd200, 16'd6144, 16'd256, 1'b0, 7'd8);
      send_request(OP_TICK, 6'd0, 16'd0, 32'd0, 24'd0, 16'd0);
      send_request(OP_TICK, 6'd0, 16'd0, 32'd0, 24'd65536, 16'd124);
      send_request(OP_KEY_WRITE, 6'd63, 16'hFFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 16'hFFFF);
      send_request(OP_KEY_WRITE, 6'd3, 16'd102, 32'h0, 24'h0, 16'h0);
      send_request(OP_KEY_WRITE, 6'd4, 16'd102, 32'h1234_5678, 24'h0, 16'h0);
      send_request(OP_TICK, 6'd0, 16'd0, 32'd0, 24'hFFFFFF, 16'hFFFF);
      send_request(OP_TICK, 6'd0, 16'd0, 32'd0, 24'd1000, 16'd200);
      // negative speed walks back and clamps at the start
      configure(16'd100, 16'd200, 16'hFFFF, 16'h8000, 1'b0, 7'd8);
      send_request(OP_TICK, 6'd0, 16'd0, 32'd0, 24'd300, 16'd150);
      send_request(OP_TICK, 6'd0, 16'd0, 32'd0, 24'hFFFFFF, 16'd100);
      // looping, zero frame rate, zero duration, oversized key count
      configure(16'd100, 16'd200, 16'd6144, 16'h7FFF, 1'b1, 7'd64);
      send_request(OP_TICK, 6'd0, 16'd0, 32'd0, 24'd4000, 16'd150);
      send_request(OP_TICK, 6'd0, 16'd0, 32'd0, 24'hFFFFFF, 16'd0);
      configure(16'd100, 16'd200, 16'd0, 16'd256, 1'b1, 7'd127);
      send_request(OP_TICK, 6'd0, 16'd0, 32'd0, 24'hFFFFFF, 16'd100);
      configure(16'hFFFF, 16'd0, 16'd1, 16'd256, 1'b0, 7'd1);
      send_request(OP_TICK, 6'd0, 16'd0, 32'd0, 24'd5000, 16'hFFFF);
      configure(16'hFFFF, 16'hFFFF, 16'd6144, 16'd256, 1'b1, 7'd0);
      send_request(OP_TICK, 6'd0, 16'd0, 32'd0, 24'd5000, 16'hFFFF);
      // shrink the clip under an elapsed time that is past the new end
      configure(16'd0, 16'hFFFF, 16'd6144, 16'd256, 1'b0, 7'd2);
      send_request(OP_TICK, 6'd0, 16'd0, 32'd0, 24'hFFFFFF, 16'd0);
      configure(16'd0, 16'd10, 16'd6144, 16'd256, 1'b0, 7'd2);
      send_request(OP_KEY_WRITE, 6'd0, 16'd0, 32'hA5A5_A5A5, 24'h0, 16'd10);

      // random phases over many clip settings
      while (sent < 1120) begin
         gaps_on = (phases % 4) != 1;
         stalls_on = (phases % 4) != 2;
         sf = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
         configure(sf,
                   ($urandom_range(0, 9) == 0) ? 16'($urandom)
                   : 16'(sf + $urandom_range(0, 300)),
                   ($urandom_range(0, 7) == 0) ? 16'($urandom)
                   : 16'($urandom_range(1, 240) * 64),
                   pick_speed(), 1'($urandom), 7'($urandom_range(0, 70)));
         if ($urandom_range(0, 1)) load_sorted_keys($urandom_range(2, 64));
         random_phase(40);
         if (phases % 5 == 0) wait_idle();
         random_phase(50);
      end

      wait_idle();
      repeat (300) @(posedge clock);
      $display("covered %0d requests (%0d ticks) over %0d clip settings,", sent, ticks, phases);
      $display("with loop and clamp, negative speed, empty and full key tables");
      if (fail_count == 0 && pending == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/kcs_pkg.sv
sv/kcs_key_ram.sv
sv/kcs_divider.sv
sv/keyframe_clip_sampler_top.sv
tb/keyframe_clip_checker.sv
tb/testbench.sv
